FILE: rtl/sbtl_pkg.sv
// ----------------------------------------------------------------------------
// sbtl_pkg
// Shared types and constants for the serial bus byte talker/listener engine.
// ----------------------------------------------------------------------------
package sbtl_pkg;

	localparam int TIMER_BITS = 24;
	localparam int CFG_COUNT  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 24;
	localparam int BITS_W     = 4;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX           = '1;
	localparam logic [TIMER_BITS-1:0] EOI_RELEASE_TIMEOUT = TIMER_BITS'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EOI_DETECT    = 3'd0,
		CFG_EOI_ACK_HOLD  = 3'd1,
		CFG_BIT_SETUP     = 3'd2,
		CFG_BIT_VALID     = 3'd3,
		CFG_PRE_SEND      = 3'd4,
		CFG_BIT_TIMEOUT   = 3'd5,
		CFG_ACK_TIMEOUT   = 3'd6,
		CFG_START_TIMEOUT = 3'd7
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
		24'd200, 24'd60, 24'd20, 24'd60, 24'd20, 24'd1000, 24'd1000, 24'd100000
	};

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_RX    = 2'd1,
		ACT_TX    = 2'd2,
		ACT_SPARE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_R_WAIT_CLK  = 4'd1,
		PH_R_EOI_HOLD  = 4'd2,
		PH_R_BIT_REL   = 4'd3,
		PH_R_BIT_ASS   = 4'd4,
		PH_S_WAIT_DATA = 4'd5,
		PH_S_EOI_ACK   = 4'd6,
		PH_S_EOI_REL   = 4'd7,
		PH_S_PRE       = 4'd8,
		PH_S_PRE_ABORT = 4'd9,
		PH_S_SETUP     = 4'd10,
		PH_S_VALID     = 4'd11,
		PH_S_FRAME_ACK = 4'd12
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] tx_byte;
		logic       tx_eoi;
		logic       clk_line;
		logic       data_line;
		logic       atn_line;
		logic       bus_busy;
	} in_t;

	typedef struct packed {
		logic       clk_drive;
		logic       data_drive;
		logic       done_res;
		logic       ok;
		logic [7:0] rx_byte;
		logic       rx_eoi;
		logic       atn_at_start;
		logic       atn_abort;
	} out_t;

endpackage

FILE: rtl/serial_bus_byte_talker_listener.sv
// ----------------------------------------------------------------------------
// serial_bus_byte_talker_listener
// Bit-level byte engine for the three-line open-collector serial bus.
// ----------------------------------------------------------------------------
//  channel  | direction | word                          | handshake
//  ---------+-----------+-------------------------------+------------------
//  in       | input     | action, tx byte, sampled lines| in_valid/in_ready
//  out      | output    | line drives, done, status     | out_valid/out_ready
//  cfg      | input     | register index, 24-bit value  | cfg_valid/cfg_ready
//
//  One word per cycle while out_ready does not stall the result: a word is
//  held in the input register, the phase update is done in one pass and
//  lands in the result register, which raises out_valid.
//  Reset loads the timing registers with their defaults and idles the bus.
//  A stalled result holds the input register; cfg_ready is always high.
// ----------------------------------------------------------------------------
module serial_bus_byte_talker_listener (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sbtl_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sbtl_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbtl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbtl_pkg::CFG_W-1:0]        cfg_data
);

	function automatic logic [sbtl_pkg::TIMER_BITS-1:0] tinc(
			input logic [sbtl_pkg::TIMER_BITS-1:0] v);
		tinc = (v == sbtl_pkg::TIMER_MAX) ? v : v + sbtl_pkg::TIMER_BITS'(1);
	endfunction

	logic [sbtl_pkg::CFG_W-1:0] cfg_q [sbtl_pkg::CFG_COUNT];

	sbtl_pkg::in_t  in_s1;
	logic           vld_s1;
	sbtl_pkg::out_t res_s2;
	logic           vld_s2;
	logic           advance;

	sbtl_pkg::phase_t                  phase_q, n_phase;
	logic [sbtl_pkg::BITS_W-1:0]       bit_q, n_bit;
	logic [7:0]                        shift_q, n_shift;
	logic [sbtl_pkg::TIMER_BITS-1:0]   el_q, n_el, el_inc;
	logic [sbtl_pkg::TIMER_BITS-1:0]   hold_q, n_hold, hold_inc;
	logic                              eoi_q, n_eoi;
	logic                              want_q, n_want;
	logic                              atn_q, n_atn;
	logic                              clk_q, n_clk;
	logic                              data_q, n_data;

	logic                           fin_done, fin_ok, fin_atn, is_rx;
	logic [7:0]                     fin_rx;
	logic [sbtl_pkg::BITS_W-1:0]    bit_inc;
	logic [7:0]                     shift_dn;
	sbtl_pkg::out_t                 res;

	assign advance   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign out_valid = vld_s2;
	assign out_data  = res_s2;
	assign cfg_ready = 1'b1;

	assign el_inc   = tinc(el_q);
	assign hold_inc = tinc(hold_q);
	assign bit_inc  = bit_q + sbtl_pkg::BITS_W'(1);
	assign shift_dn = {1'b0, shift_q[7:1]};

	always_comb begin
		n_phase  = phase_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_el     = el_q;
		n_hold   = hold_q;
		n_eoi    = eoi_q;
		n_want   = want_q;
		n_atn    = atn_q;
		n_clk    = clk_q;
		n_data   = data_q;
		fin_done = 1'b0;
		fin_ok   = 1'b0;
		fin_atn  = 1'b0;
		fin_rx   = 8'd0;
		is_rx    = 1'b0;

		if (phase_q == sbtl_pkg::PH_IDLE && in_s1.action == sbtl_pkg::ACT_RX) begin
			n_eoi   = 1'b0;
			n_atn   = in_s1.atn_line;
			n_data  = 1'b0;
			n_bit   = '0;
			n_shift = '0;
			n_el    = '0;
			n_hold  = '0;
			n_phase = sbtl_pkg::PH_R_WAIT_CLK;
		end else if (phase_q == sbtl_pkg::PH_IDLE && in_s1.action == sbtl_pkg::ACT_TX) begin
			if (in_s1.atn_line || in_s1.bus_busy) begin
				fin_done = 1'b1;
			end else begin
				n_shift = in_s1.tx_byte;
				n_want  = in_s1.tx_eoi;
				n_bit   = '0;
				n_el    = '0;
				n_hold  = '0;
				n_clk   = 1'b0;
				n_phase = sbtl_pkg::PH_S_WAIT_DATA;
			end
		end else if (phase_q != sbtl_pkg::PH_IDLE) begin
			is_rx = (phase_q == sbtl_pkg::PH_R_WAIT_CLK) || (phase_q == sbtl_pkg::PH_R_EOI_HOLD) ||
				(phase_q == sbtl_pkg::PH_R_BIT_REL) || (phase_q == sbtl_pkg::PH_R_BIT_ASS);
			unique case (phase_q)
				sbtl_pkg::PH_R_WAIT_CLK: begin
					if (in_s1.clk_line) begin
						n_el    = '0;
						n_phase = sbtl_pkg::PH_R_BIT_REL;
					end else begin
						n_el = el_inc;
						if (!eoi_q && el_inc >= cfg_q[sbtl_pkg::CFG_EOI_DETECT]) begin
							n_data  = 1'b1;
							n_hold  = '0;
							n_phase = sbtl_pkg::PH_R_EOI_HOLD;
						end
						if (el_inc > cfg_q[sbtl_pkg::CFG_START_TIMEOUT]) begin
							n_data   = 1'b1;
							n_phase  = sbtl_pkg::PH_IDLE;
							fin_done = 1'b1;
						end
					end
				end
				sbtl_pkg::PH_R_EOI_HOLD: begin
					n_el   = el_inc;
					n_hold = hold_inc;
					if (hold_inc >= cfg_q[sbtl_pkg::CFG_EOI_ACK_HOLD]) begin
						n_data  = 1'b0;
						n_eoi   = 1'b1;
						n_phase = sbtl_pkg::PH_R_WAIT_CLK;
						if (el_inc > cfg_q[sbtl_pkg::CFG_START_TIMEOUT]) begin
							n_data   = 1'b1;
							n_phase  = sbtl_pkg::PH_IDLE;
							fin_done = 1'b1;
						end
					end
				end
				sbtl_pkg::PH_R_BIT_REL: begin
					if (!in_s1.clk_line) begin
						// released DATA on the CLK release is a one
						if (!in_s1.data_line) begin
							n_shift = shift_q | (8'd1 << bit_q[2:0]);
						end
						n_el    = '0;
						n_phase = sbtl_pkg::PH_R_BIT_ASS;
					end else begin
						n_el = el_inc;
						if (el_inc >= cfg_q[sbtl_pkg::CFG_BIT_TIMEOUT]) begin
							n_data   = 1'b1;
							n_phase  = sbtl_pkg::PH_IDLE;
							fin_done = 1'b1;
						end
					end
				end
				sbtl_pkg::PH_R_BIT_ASS: begin
					if (!in_s1.clk_line) begin
						n_el = el_inc;
					end
					if (!in_s1.clk_line && el_inc >= cfg_q[sbtl_pkg::CFG_BIT_TIMEOUT] &&
						bit_q < sbtl_pkg::BITS_W'(7)) begin
						n_data   = 1'b1;
						n_phase  = sbtl_pkg::PH_IDLE;
						fin_done = 1'b1;
					end else if (in_s1.clk_line ||
						el_inc >= cfg_q[sbtl_pkg::CFG_BIT_TIMEOUT]) begin
						// a timeout after the last bit still closes the frame
						n_bit = bit_inc;
						if (bit_inc >= sbtl_pkg::BITS_W'(8)) begin
							n_data   = 1'b1;
							n_phase  = sbtl_pkg::PH_IDLE;
							fin_done = 1'b1;
							fin_ok   = 1'b1;
							fin_rx   = shift_q;
						end else begin
							n_el    = '0;
							n_phase = sbtl_pkg::PH_R_BIT_REL;
						end
					end
				end
				sbtl_pkg::PH_S_WAIT_DATA: begin
					if (in_s1.atn_line) begin
						n_clk   = 1'b1;
						n_hold  = '0;
						n_phase = sbtl_pkg::PH_S_PRE_ABORT;
					end else if (!in_s1.data_line) begin
						if (want_q) begin
							n_el    = '0;
							n_phase = sbtl_pkg::PH_S_EOI_ACK;
						end else begin
							n_clk   = 1'b1;
							n_hold  = '0;
							n_phase = sbtl_pkg::PH_S_PRE;
						end
					end
				end
				sbtl_pkg::PH_S_EOI_ACK: begin
					if (in_s1.atn_line) begin
						n_clk   = 1'b1;
						n_hold  = '0;
						n_phase = sbtl_pkg::PH_S_PRE_ABORT;
					end else if (in_s1.data_line) begin
						n_el    = '0;
						n_phase = sbtl_pkg::PH_S_EOI_REL;
					end else begin
						n_el = el_inc;
						if (el_inc >= cfg_q[sbtl_pkg::CFG_ACK_TIMEOUT]) begin
							n_clk   = 1'b1;
							n_hold  = '0;
							n_phase = sbtl_pkg::PH_S_PRE_ABORT;
						end
					end
				end
				sbtl_pkg::PH_S_EOI_REL: begin
					if (in_s1.atn_line) begin
						n_clk   = 1'b1;
						n_hold  = '0;
						n_phase = sbtl_pkg::PH_S_PRE_ABORT;
					end else if (!in_s1.data_line) begin
						n_clk   = 1'b1;
						n_hold  = '0;
						n_phase = sbtl_pkg::PH_S_PRE;
					end else begin
						n_el = el_inc;
						if (el_inc >= sbtl_pkg::EOI_RELEASE_TIMEOUT) begin
							n_clk   = 1'b1;
							n_hold  = '0;
							n_phase = sbtl_pkg::PH_S_PRE_ABORT;
						end
					end
				end
				sbtl_pkg::PH_S_PRE, sbtl_pkg::PH_S_PRE_ABORT: begin
					n_hold = hold_inc;
					if (hold_inc >= cfg_q[sbtl_pkg::CFG_PRE_SEND]) begin
						if (phase_q == sbtl_pkg::PH_S_PRE_ABORT || in_s1.atn_line) begin
							n_phase  = sbtl_pkg::PH_IDLE;
							fin_done = 1'b1;
							if (in_s1.atn_line) begin
								n_clk   = 1'b0;
								fin_atn = 1'b1;
							end
						end else begin
							n_data  = ~shift_q[0];
							n_hold  = '0;
							n_phase = sbtl_pkg::PH_S_SETUP;
						end
					end
				end
				sbtl_pkg::PH_S_SETUP: begin
					n_hold = hold_inc;
					if (hold_inc >= cfg_q[sbtl_pkg::CFG_BIT_SETUP]) begin
						n_clk   = 1'b0;
						n_hold  = '0;
						n_phase = sbtl_pkg::PH_S_VALID;
					end
				end
				sbtl_pkg::PH_S_VALID: begin
					n_hold = hold_inc;
					if (hold_inc >= cfg_q[sbtl_pkg::CFG_BIT_VALID]) begin
						n_data  = 1'b0;
						n_clk   = 1'b1;
						n_shift = shift_dn;
						n_bit   = bit_inc;
						if (bit_inc >= sbtl_pkg::BITS_W'(8)) begin
							n_el    = '0;
							n_phase = sbtl_pkg::PH_S_FRAME_ACK;
						end else if (in_s1.atn_line) begin
							n_clk    = 1'b0;
							n_phase  = sbtl_pkg::PH_IDLE;
							fin_done = 1'b1;
							fin_atn  = 1'b1;
						end else begin
							n_data  = ~shift_dn[0];
							n_hold  = '0;
							n_phase = sbtl_pkg::PH_S_SETUP;
						end
					end
				end
				sbtl_pkg::PH_S_FRAME_ACK: begin
					if (in_s1.atn_line) begin
						n_clk    = 1'b0;
						n_phase  = sbtl_pkg::PH_IDLE;
						fin_done = 1'b1;
						fin_atn  = 1'b1;
					end else if (in_s1.data_line) begin
						n_phase  = sbtl_pkg::PH_IDLE;
						fin_done = 1'b1;
						fin_ok   = 1'b1;
					end else begin
						n_el = el_inc;
						// no acknowledgement is still taken as delivered
						if (el_inc >= cfg_q[sbtl_pkg::CFG_ACK_TIMEOUT]) begin
							n_phase  = sbtl_pkg::PH_IDLE;
							fin_done = 1'b1;
							fin_ok   = 1'b1;
						end
					end
				end
				default: begin
					n_phase = sbtl_pkg::PH_IDLE;
				end
			endcase
		end

		res.clk_drive    = n_clk;
		res.data_drive   = n_data;
		res.done_res     = fin_done;
		res.ok           = fin_done && fin_ok;
		res.rx_byte      = (fin_done && is_rx) ? fin_rx : 8'd0;
		res.rx_eoi       = fin_done && is_rx && n_eoi;
		res.atn_at_start = fin_done && is_rx && n_atn;
		res.atn_abort    = fin_done && !is_rx && fin_atn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbtl_pkg::CFG_COUNT; i++) begin
				cfg_q[i] <= sbtl_pkg::CFG_RESET[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbtl_pkg::PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			el_q    <= '0;
			hold_q  <= '0;
			eoi_q   <= 1'b0;
			want_q  <= 1'b0;
			atn_q   <= 1'b0;
			clk_q   <= 1'b0;
			data_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= n_phase;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			el_q    <= n_el;
			hold_q  <= n_hold;
			eoi_q   <= n_eoi;
			want_q  <= n_want;
			atn_q   <= n_atn;
			clk_q   <= n_clk;
			data_q  <= n_data;
		end
	end

endmodule

FILE: rtl/sbtl_checker.sv
// ----------------------------------------------------------------------------
// sbtl_checker
// Port-level checks for the serial bus byte talker/listener.
// ----------------------------------------------------------------------------
module sbtl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input sbtl_pkg::out_t                 out_data
);

	// status fields are all clear on a word that closes no transfer
	a_idle_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |->
			!out_data.ok && out_data.rx_byte == 8'd0 && !out_data.rx_eoi &&
			!out_data.atn_at_start && !out_data.atn_abort)
		else $error("status set without done");

	// an ATN abort ends a send: no receive fields, no success
	a_abort_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.atn_abort |->
			!out_data.ok && out_data.rx_byte == 8'd0 && !out_data.rx_eoi &&
			!out_data.atn_at_start)
		else $error("ATN abort mixed with receive status");

	// the bus is handed back with CLK released on an ATN abort
	a_abort_clk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.atn_abort |-> !out_data.clk_drive)
		else $error("CLK still driven after ATN abort");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed while stalled");

endmodule

bind serial_bus_byte_talker_listener sbtl_checker u_sbtl_checker (.*);
